>>> rtl/jxe_pkg.sv
package jxe_pkg;

    localparam int unsigned PhaseW = 4;

    localparam logic [PhaseW-1:0] PH_SOI0  = 4'd0;
    localparam logic [PhaseW-1:0] PH_SOI1  = 4'd1;
    localparam logic [PhaseW-1:0] PH_MARK0 = 4'd2;
    localparam logic [PhaseW-1:0] PH_MARK1 = 4'd3;
    localparam logic [PhaseW-1:0] PH_LENHI = 4'd4;
    localparam logic [PhaseW-1:0] PH_LENLO = 4'd5;
    localparam logic [PhaseW-1:0] PH_SKIP  = 4'd6;
    localparam logic [PhaseW-1:0] PH_ID    = 4'd7;
    localparam logic [PhaseW-1:0] PH_EMIT  = 4'd8;
    localparam logic [PhaseW-1:0] PH_DONE  = 4'd9;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_APP1   = 8'hE1;

    localparam logic [2:0]  ID_LEN      = 3'd6;
    localparam logic [15:0] APP1_MINLEN = 16'd9;

    typedef struct packed {
        logic [7:0] exif_byte;
        logic       byte_valid;
        logic       final_result;
        logic       found;
    } t_result;

    typedef struct packed {
        logic              res_valid;
        t_result           res;
        logic [PhaseW-1:0] phase;
    } t_parse_out;

    function automatic logic [7:0] exif_ident(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h45;
            3'd1:    v = 8'h78;
            3'd2:    v = 8'h69;
            3'd3:    v = 8'h66;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/jpeg_exif_segment_extractor.sv
// JPEG Exif segment extractor.
// Slave stream: one file byte per word (tdata[7:0]), tlast on the final byte.
// Master stream: tdata[7:0] is a payload byte, tuser[0] byte valid, tuser[1]
// found, tlast on the last result for the file. Payload bytes follow the
// "Exif\0\0" identifier of the first suitable APP1 segment; if none is found,
// or the file is corrupt or ends early, one word with tuser = 0 and tlast = 1
// is sent instead.
// Config channel: i_cfg_data loads the file length in bytes; always ready.
// Write it between files.
// Each byte is parsed in the cycle it is accepted; a result appears on the
// master side in the cycle after the causing byte. One byte per cycle
// sustained; the single output register is the only buffer, so s_axis_tready
// drops while a result waits and m_axis_tready is low.
// Bytes after the outcome is settled are absorbed until tlast, after which
// the parser expects a new start-of-image marker.
// Reset (i_rst_n low, synchronous) clears the parser, the output valid flag
// and the length register.
module jpeg_exif_segment_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] exif_byte
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] found
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import jxe_pkg::*;

    logic       r_out_valid;
    t_result    r_out;
    logic [31:0] r_stream_len;
    t_parse_out parse;
    logic       s_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    jxe_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s_accept),
        .i_byte       (s_axis_tdata),
        .i_eos        (s_axis_tlast),
        .i_stream_len (r_stream_len),
        .o_out        (parse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_len <= 32'd0;
        end else if (i_cfg_valid) begin
            r_stream_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept && parse.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && parse.res_valid) begin
            r_out <= parse.res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.exif_byte;
    assign m_axis_tuser  = {r_out.found, r_out.byte_valid};
    assign m_axis_tlast  = r_out.final_result;

    a_nf_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("not-found word without tlast");

    a_found_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[0] == m_axis_tuser[1])
        else $error("found and byte valid disagree");

    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tlast |=> parse.phase == PH_SOI0)
        else $error("parser not restarted after last byte");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tlast && parse.res_valid |-> parse.res.final_result)
        else $error("result on last byte not final");

endmodule

>>> rtl/jxe_parser.sv
module jxe_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_eos,
    input  logic [31:0]         i_stream_len,
    output jxe_pkg::t_parse_out o_out
);
    import jxe_pkg::*;

    logic [PhaseW-1:0] r_phase,    n_phase;
    logic [31:0]       r_offset,   n_offset;
    logic              r_is_app1,  n_is_app1;
    logic [15:0]       r_seg_len,  n_seg_len;
    logic [15:0]       r_seg_rem,  n_seg_rem;
    logic [2:0]        r_id_idx,   n_id_idx;

    logic        res_v;
    t_result     res;
    logic        do_adv;
    logic [31:0] adv_base;
    logic [16:0] adv_step;
    logic [15:0] len16;
    logic [15:0] rem_dec;
    logic [33:0] seg_end;
    logic [32:0] adv_room;

    always_comb begin
        n_phase   = r_phase;
        n_offset  = r_offset;
        n_is_app1 = r_is_app1;
        n_seg_len = r_seg_len;
        n_seg_rem = r_seg_rem;
        n_id_idx  = r_id_idx;
        res_v     = 1'b0;
        res       = '{exif_byte: 8'h00, byte_valid: 1'b0, final_result: 1'b1, found: 1'b0};
        do_adv    = 1'b0;
        adv_base  = r_offset;
        adv_step  = 17'd2;
        len16     = {r_seg_len[15:8], i_byte};
        rem_dec   = r_seg_rem - 16'd1;
        seg_end   = {2'b00, r_offset} + 34'd2 + {18'd0, len16};
        adv_room  = 33'd0;

        unique case (r_phase)
            PH_SOI0: begin
                if (i_stream_len < 32'd4 || i_byte != MK_PREFIX) begin
                    res_v   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_SOI1;
                end
            end
            PH_SOI1: begin
                if (i_byte != MK_SOI) begin
                    res_v   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    adv_base = 32'd0;
                    do_adv   = 1'b1;
                end
            end
            PH_MARK0: begin
                if (i_byte != MK_PREFIX) begin
                    res_v   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_MARK1;
                end
            end
            PH_MARK1: begin
                if (i_byte == MK_SOI || (i_byte >= MK_RST0 && i_byte <= MK_RST7)) begin
                    do_adv = 1'b1;
                end else if (i_byte == MK_SOS || i_byte == MK_EOI) begin
                    res_v   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_is_app1 = (i_byte == MK_APP1);
                    n_phase   = PH_LENHI;
                end
            end
            PH_LENHI: begin
                n_seg_len = {i_byte, 8'h00};
                n_phase   = PH_LENLO;
            end
            PH_LENLO: begin
                n_seg_len = len16;
                if (len16 < 16'd2 || seg_end > {2'b00, i_stream_len}) begin
                    res_v   = 1'b1;
                    n_phase = PH_DONE;
                end else if (len16 == 16'd2) begin
                    adv_step = 17'd4;
                    do_adv   = 1'b1;
                end else begin
                    n_seg_rem = len16 - 16'd2;
                    n_id_idx  = 3'd0;
                    n_phase   = (r_is_app1 && len16 >= APP1_MINLEN) ? PH_ID : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_seg_rem = rem_dec;
                adv_step  = {1'b0, r_seg_len} + 17'd2;
                do_adv    = (rem_dec == 16'd0);
            end
            PH_ID: begin
                n_seg_rem = rem_dec;
                if (r_id_idx < ID_LEN && i_byte == exif_ident(r_id_idx)) begin
                    n_id_idx = r_id_idx + 3'd1;
                    if (r_id_idx + 3'd1 == ID_LEN) begin
                        n_phase = PH_EMIT;
                    end
                end else begin
                    n_phase = PH_SKIP;
                end
                adv_step = {1'b0, r_seg_len} + 17'd2;
                do_adv   = (rem_dec == 16'd0);
            end
            PH_EMIT: begin
                n_seg_rem = rem_dec;
                res_v     = 1'b1;
                res       = '{exif_byte: i_byte, byte_valid: 1'b1,
                              final_result: (rem_dec == 16'd0), found: 1'b1};
                if (rem_dec == 16'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        // step to next marker position, need four bytes left
        if (do_adv) begin
            n_offset = adv_base + {15'd0, adv_step};
            adv_room = {1'b0, n_offset} + 33'd4;
            if (adv_room > {1'b0, i_stream_len}) begin
                res_v   = 1'b1;
                res     = '{exif_byte: 8'h00, byte_valid: 1'b0, final_result: 1'b1,
                            found: 1'b0};
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_MARK0;
            end
        end

        if (i_eos) begin
            if ((res_v && !res.final_result) || (!res_v && n_phase != PH_DONE)) begin
                res_v = 1'b1;
                res   = '{exif_byte: 8'h00, byte_valid: 1'b0, final_result: 1'b1,
                          found: 1'b0};
            end
            n_phase   = PH_SOI0;
            n_offset  = 32'd0;
            n_is_app1 = 1'b0;
            n_seg_len = 16'd0;
            n_seg_rem = 16'd0;
            n_id_idx  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SOI0;
            r_offset  <= 32'd0;
            r_is_app1 <= 1'b0;
            r_seg_len <= 16'd0;
            r_seg_rem <= 16'd0;
            r_id_idx  <= 3'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_is_app1 <= n_is_app1;
            r_seg_len <= n_seg_len;
            r_seg_rem <= n_seg_rem;
            r_id_idx  <= n_id_idx;
        end
    end

    assign o_out = '{res_valid: res_v, res: res, phase: r_phase};

endmodule
